### hdl/ctcf_pkg.sv
package ctcf_pkg;

    localparam int unsigned MaxRes = 3;

    typedef enum logic [1:0] {
        ESC_NORMAL    = 2'd0,
        ESC_AFTER_BSL = 2'd1,
        ESC_SKIP_ARG  = 2'd2
    } esc_t;

    typedef enum logic {
        REG_RICH_TEXT_MODE = 1'b0
    } reg_idx_t;

    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChLbrace    = 8'h7B;
    localparam logic [7:0] ChRbrace    = 8'h7D;
    localparam logic [7:0] ChSemicolon = 8'h3B;
    localparam logic [7:0] ChPercent   = 8'h25;
    localparam logic [7:0] ChNewline   = 8'h0A;
    localparam logic [7:0] ChUpperP    = 8'h50;
    localparam logic [7:0] ChLowerP    = 8'h70;
    localparam logic [7:0] ChLowerD    = 8'h64;
    localparam logic [7:0] ChLowerC    = 8'h63;
    localparam logic [7:0] ChLowerU    = 8'h75;
    localparam logic [7:0] ChLowerO    = 8'h6F;
    localparam logic [7:0] ChUpperA    = 8'h41;
    localparam logic [7:0] ChUpperZ    = 8'h5A;
    localparam logic [7:0] CaseOffset  = 8'h20;

    localparam logic [7:0] SymDegree0    = 8'hC2;
    localparam logic [7:0] SymDegree1    = 8'hB0;
    localparam logic [7:0] SymPlusMinus0 = 8'hC2;
    localparam logic [7:0] SymPlusMinus1 = 8'hB1;
    localparam logic [7:0] SymDiameter0  = 8'hC3;
    localparam logic [7:0] SymDiameter1  = 8'h98;

    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic       end_of_text;
    } res_ent_t;

endpackage

### hdl/cad_text_code_filter.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_char_in[7:0], s_last_in
// m_        out        m_valid / m_ready  m_char_out[7:0], m_char_valid, m_end_of_text
// cfg       in         APB psel/penable   paddr[2:0], pwdata[31:0], prdata[31:0]
//
// Each request is decoded in the cycle it is accepted and yields zero to three
// results, loaded into a three-entry result buffer that drains one per cycle
// while m_ready is high. A new request is taken when the buffer is empty or holds
// its final entry being taken, so single-result requests flow at one per cycle
// while m_ready is high; a k-result request blocks the next until its last is taken.
// Reset (aresetn low, synchronous) clears the buffer and escape/percent state
// and sets rich_text_mode to 1.
module cad_text_code_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_in,
    input  logic        s_last_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_char_out,
    output logic        m_char_valid,
    output logic        m_end_of_text,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ctcf_pkg::*;

    logic           rich_reg;
    esc_t           esc_reg;
    esc_t           esc_next;
    logic [1:0]     pend_reg;
    logic [1:0]     pend_next;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    res_ent_t       ent_reg  [MaxRes];
    res_ent_t       ent_next [MaxRes];

    logic           s_acc;
    logic           m_pop;
    logic           cfg_wr;
    reg_idx_t       cfg_idx;

    logic           feed_vld;
    logic [7:0]     feed_byte;
    logic           do_normal;
    logic           is_esc_lit;
    logic [1:0]     pend_cur;
    logic [7:0]     lc;
    logic [7:0]     res_b [MaxRes];
    logic [1:0]     res_n;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (cfg_idx == REG_RICH_TEXT_MODE) ? {31'd0, rich_reg} : 32'd0;

    assign m_valid       = (cnt_reg != 2'd0);
    assign m_char_out    = ent_reg[0].char_out;
    assign m_char_valid  = ent_reg[0].char_valid;
    assign m_end_of_text = ent_reg[0].end_of_text;
    assign m_pop         = m_valid && m_ready;
    assign s_ready       = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);
    assign s_acc         = s_valid && s_ready;

    assign is_esc_lit = (s_char_in == ChBackslash) || (s_char_in == ChLbrace) ||
                        (s_char_in == ChRbrace);

    // formatting stage
    always_comb begin
        feed_vld  = 1'b0;
        feed_byte = s_char_in;
        esc_next  = esc_reg;
        do_normal = 1'b0;
        if (!rich_reg) begin
            esc_next = ESC_NORMAL;
            feed_vld = 1'b1;
        end else begin
            unique case (esc_reg)
                ESC_AFTER_BSL: begin
                    esc_next = ESC_NORMAL;
                    if ((s_char_in == ChUpperP) || (s_char_in == ChLowerP)) begin
                        feed_vld  = 1'b1;
                        feed_byte = ChNewline;
                    end else if (is_esc_lit) begin
                        feed_vld = 1'b1;
                    end else begin
                        esc_next = ESC_SKIP_ARG;
                    end
                end
                ESC_SKIP_ARG: begin
                    if (s_char_in == ChSemicolon) begin
                        esc_next = ESC_NORMAL;
                    end else if (is_esc_lit) begin
                        do_normal = 1'b1;
                    end
                end
                default: begin
                    do_normal = 1'b1;
                end
            endcase
            if (do_normal) begin
                esc_next = ESC_NORMAL;
                if (s_char_in == ChBackslash) begin
                    if (s_last_in) begin
                        feed_vld = 1'b1;
                    end else begin
                        esc_next = ESC_AFTER_BSL;
                    end
                end else if ((s_char_in != ChLbrace) && (s_char_in != ChRbrace)) begin
                    feed_vld = 1'b1;
                end
            end
        end
        if (s_last_in) begin
            esc_next = ESC_NORMAL;
        end
    end

    // percent stage and end flush
    always_comb begin
        pend_cur  = (pend_reg == 2'd3) ? 2'd2 : pend_reg;
        lc        = ((feed_byte >= ChUpperA) && (feed_byte <= ChUpperZ)) ?
                    feed_byte + CaseOffset : feed_byte;
        pend_next = pend_cur;
        res_n     = 2'd0;
        for (int i = 0; i < MaxRes; i++) begin
            res_b[i] = 8'd0;
        end
        if (feed_vld) begin
            if (pend_cur == 2'd2) begin
                pend_next = 2'd0;
                priority if (lc == ChLowerD) begin
                    res_b[0] = SymDegree0;
                    res_b[1] = SymDegree1;
                    res_n    = 2'd2;
                end else if (lc == ChLowerP) begin
                    res_b[0] = SymPlusMinus0;
                    res_b[1] = SymPlusMinus1;
                    res_n    = 2'd2;
                end else if (lc == ChLowerC) begin
                    res_b[0] = SymDiameter0;
                    res_b[1] = SymDiameter1;
                    res_n    = 2'd2;
                end else if (lc == ChPercent) begin
                    res_b[0] = ChPercent;
                    res_n    = 2'd1;
                end else if ((lc == ChLowerU) || (lc == ChLowerO)) begin
                    res_n    = 2'd0;
                end else begin
                    res_b[0] = ChPercent;
                    res_b[1] = ChPercent;
                    res_b[2] = feed_byte;
                    res_n    = 2'd3;
                end
            end else if (feed_byte == ChPercent) begin
                pend_next = pend_cur + 2'd1;
            end else begin
                pend_next = 2'd0;
                if (pend_cur == 2'd1) begin
                    res_b[0] = ChPercent;
                    res_b[1] = feed_byte;
                    res_n    = 2'd2;
                end else begin
                    res_b[0] = feed_byte;
                    res_n    = 2'd1;
                end
            end
        end
        // held percents imply nothing was emitted yet
        if (s_last_in && (pend_next != 2'd0)) begin
            res_b[0]  = ChPercent;
            res_b[1]  = ChPercent;
            res_n     = pend_next;
            pend_next = 2'd0;
        end else if (s_last_in) begin
            pend_next = 2'd0;
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        for (int i = 0; i < MaxRes; i++) begin
            ent_next[i] = ent_reg[i];
        end
        if (s_acc) begin
            for (int i = 0; i < MaxRes; i++) begin
                ent_next[i].char_out    = res_b[i];
                ent_next[i].char_valid  = 1'b1;
                ent_next[i].end_of_text = s_last_in && (2'(i) == res_n - 2'd1);
            end
            cnt_next = res_n;
            if (s_last_in && (res_n == 2'd0)) begin
                ent_next[0].char_out    = 8'd0;
                ent_next[0].char_valid  = 1'b0;
                ent_next[0].end_of_text = 1'b1;
                cnt_next                = 2'd1;
            end
        end else if (m_pop) begin
            ent_next[0] = ent_reg[1];
            ent_next[1] = ent_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rich_reg <= 1'b1;
            esc_reg  <= ESC_NORMAL;
            pend_reg <= 2'd0;
            cnt_reg  <= 2'd0;
        end else begin
            if (cfg_wr && (cfg_idx == REG_RICH_TEXT_MODE)) begin
                rich_reg <= pwdata[0];
            end
            if (s_acc) begin
                esc_reg  <= esc_next;
                pend_reg <= pend_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MaxRes; i++) begin
            ent_reg[i] <= ent_next[i];
        end
    end

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_last_in |=> m_valid)
        else $error("last request produced no result");

    a_last_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_last_in |=> (esc_reg == ESC_NORMAL) && (pend_reg == 2'd0))
        else $error("state not cleared at end of string");

    a_pend_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 2'd3)
        else $error("percent count out of range");

    a_plain_no_escape: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && !rich_reg |=> esc_reg == ESC_NORMAL)
        else $error("escape state set in plain mode");

    a_marker_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_char_valid |-> m_end_of_text && (cnt_reg == 2'd1))
        else $error("empty marker not at end of string");

endmodule

### test/cad_text_code_filter_test.sv
module cad_text_code_filter_test;
    import ctcf_pkg::*;

    localparam int IdleLimit = 1000;
    localparam int DrainCycles = 10;
    localparam int SettleCycles = 4;
    localparam logic [7:0] RandModes = 8'b1110_1101;

    typedef struct packed {
        logic       is_cfg;
        logic [7:0] ch;
        logic       last;
        logic       typed_en;
        logic [1:0] n_typed;
        res_ent_t [2:0] typed;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_in = 8'h00;
    logic        s_last_in = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_char_out;
    logic        m_char_valid;
    logic        m_end_of_text;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    cad_text_code_filter dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_in    (s_char_in),
        .s_last_in    (s_last_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_char_out   (m_char_out),
        .m_char_valid (m_char_valid),
        .m_end_of_text(m_end_of_text),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 aclk = ~aclk;

    // filter state as seen by the predictor
    logic       p_rich = 1'b1;
    esc_t       p_esc = ESC_NORMAL;
    logic [1:0] p_held = 2'd0;

    res_ent_t   step_res [MaxRes];
    int         step_n;
    res_ent_t   expected_chars [$];
    res_ent_t   want;
    row_t       directed_rows [$];
    row_t       pending_rows [$];
    int         failures = 0;
    int         burst_left = 0;
    int         ready_run = 0;
    int         idle_cycles = 0;

    task automatic emit(input logic [7:0] b);
        if (step_n < MaxRes) begin
            step_res[step_n] = '{char_out: b, char_valid: 1'b1, end_of_text: 1'b0};
            step_n++;
        end
    endtask

    task automatic release_held();
        int k;
        for (k = 0; k < p_held; k++) emit(ChPercent);
        p_held = 2'd0;
    endtask

    task automatic expand_percent(input logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= ChUpperA && c <= ChUpperZ) ? c + CaseOffset : c;
        if (p_held >= 2'd2) begin
            p_held = 2'd0;
            case (lc)
                ChLowerD: begin
                    emit(SymDegree0);
                    emit(SymDegree1);
                end
                ChLowerP: begin
                    emit(SymPlusMinus0);
                    emit(SymPlusMinus1);
                end
                ChLowerC: begin
                    emit(SymDiameter0);
                    emit(SymDiameter1);
                end
                ChPercent: emit(ChPercent);
                ChLowerU, ChLowerO: ;
                default: begin
                    emit(ChPercent);
                    emit(ChPercent);
                    emit(c);
                end
            endcase
        end else if (c == ChPercent) begin
            p_held = p_held + 2'd1;
        end else begin
            release_held();
            emit(c);
        end
    endtask

    task automatic plain_text(input logic [7:0] c, input logic last);
        p_esc = ESC_NORMAL;
        if (c == ChBackslash) begin
            if (last) expand_percent(c);
            else p_esc = ESC_AFTER_BSL;
        end else if (c != ChLbrace && c != ChRbrace) begin
            expand_percent(c);
        end
    endtask

    task automatic predict_request(input logic [7:0] c, input logic last);
        step_n = 0;
        if (p_held > 2'd2) p_held = 2'd2;
        if (!p_rich) begin
            p_esc = ESC_NORMAL;
            expand_percent(c);
        end else begin
            case (p_esc)
                ESC_AFTER_BSL: begin
                    p_esc = ESC_NORMAL;
                    if (c == ChUpperP || c == ChLowerP) expand_percent(ChNewline);
                    else if (c == ChBackslash || c == ChLbrace || c == ChRbrace)
                        expand_percent(c);
                    else p_esc = ESC_SKIP_ARG;
                end
                ESC_SKIP_ARG: begin
                    if (c == ChSemicolon) p_esc = ESC_NORMAL;
                    else if (c == ChBackslash || c == ChLbrace || c == ChRbrace)
                        plain_text(c, last);
                end
                default: plain_text(c, last);
            endcase
        end
        if (last) begin
            release_held();
            p_esc = ESC_NORMAL;
            if (step_n == 0) begin
                step_res[0] = '{char_out: 8'h00, char_valid: 1'b0, end_of_text: 1'b1};
                step_n = 1;
            end else begin
                step_res[step_n - 1].end_of_text = 1'b1;
            end
        end
    endtask

    function automatic res_ent_t rs(input logic [7:0] c, input logic v, input logic e);
        rs = '{char_out: c, char_valid: v, end_of_text: e};
    endfunction

    function automatic row_t itm(input logic [7:0] ch, input logic last);
        itm = '0;
        itm.ch = ch;
        itm.last = last;
    endfunction

    function automatic row_t chk(input logic [7:0] ch, input logic last, input int n,
                                 input res_ent_t e0, input res_ent_t e1);
        chk = itm(ch, last);
        chk.typed_en = 1'b1;
        chk.n_typed = 2'(n);
        chk.typed[0] = e0;
        chk.typed[1] = e1;
    endfunction

    function automatic row_t cfg(input logic mode);
        cfg = '0;
        cfg.is_cfg = 1'b1;
        cfg.ch = {7'd0, mode};
    endfunction

    task automatic add_row(input row_t r);
        directed_rows = {directed_rows, r};
    endtask

    task automatic send_row(input row_t r);
        int k;
        s_valid <= 1'b1;
        s_char_in <= r.ch;
        s_last_in <= r.last;
        do @(posedge aclk); while (!s_ready);
        predict_request(r.ch, r.last);
        if (r.typed_en) begin
            for (k = 0; k < r.n_typed; k++) expected_chars = {expected_chars, r.typed[k]};
        end else begin
            for (k = 0; k < step_n; k++) expected_chars = {expected_chars, step_res[k]};
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic write_mode(input logic mode);
        if (s_valid) s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * int'(REG_RICH_TEXT_MODE));
        pwdata <= ($urandom() & ~32'd1) | 32'(mode);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        p_rich = mode;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        if (prdata !== {31'd0, mode}) begin
            $error("prdata: expected %0h, actual %0h", {31'd0, mode}, prdata);
            failures++;
        end
    endtask

    task automatic queue_string();
        logic [7:0] bytes [$];
        logic [7:0] code;
        int tokens;
        int t;
        int k;
        tokens = $urandom_range(1, 6);
        for (t = 0; t < tokens; t++) begin
            case ($urandom_range(0, 11))
                0, 1: bytes = {bytes, 8'($urandom_range(8'h20, 8'h7E))};
                2, 3: begin
                    bytes = {bytes, ChPercent};
                    bytes = {bytes, ChPercent};
                    case ($urandom_range(0, 11))
                        0: code = "d";
                        1: code = "D";
                        2: code = "p";
                        3: code = "P";
                        4: code = "c";
                        5: code = "C";
                        6: code = "u";
                        7: code = "U";
                        8: code = "o";
                        9: code = "O";
                        10: code = ChPercent;
                        default: code = 8'($urandom_range(0, 255));
                    endcase
                    bytes = {bytes, code};
                end
                4: begin
                    bytes = {bytes, ChBackslash};
                    code = $urandom_range(0, 1) ? ChUpperP : ChLowerP;
                    bytes = {bytes, code};
                end
                5: begin
                    bytes = {bytes, ChBackslash};
                    case ($urandom_range(0, 2))
                        0: bytes = {bytes, ChBackslash};
                        1: bytes = {bytes, ChLbrace};
                        default: bytes = {bytes, ChRbrace};
                    endcase
                end
                6: begin
                    bytes = {bytes, ChBackslash};
                    code = 8'($urandom_range(ChUpperA, ChUpperZ));
                    if (code == ChUpperP) code = "H";
                    bytes = {bytes, code};
                    repeat ($urandom_range(0, 3)) begin
                        bytes = {bytes, 8'($urandom_range(8'h30, 8'h39))};
                    end
                    case ($urandom_range(0, 5))
                        0: bytes = {bytes, ChLbrace};
                        1: bytes = {bytes, ChBackslash};
                        2: ;
                        default: bytes = {bytes, ChSemicolon};
                    endcase
                end
                7: begin
                    code = $urandom_range(0, 1) ? ChLbrace : ChRbrace;
                    bytes = {bytes, code};
                end
                8: bytes = {bytes, 8'($urandom_range(0, 255))};
                9: bytes = {bytes, ChPercent};
                10: begin
                    bytes = {bytes, ChPercent};
                    bytes = {bytes, ChPercent};
                end
                default: begin
                    case ($urandom_range(0, 4))
                        0: bytes = {bytes, ChBackslash};
                        1: bytes = {bytes, ChPercent};
                        2: bytes = {bytes, ChSemicolon};
                        3: bytes = {bytes, ChLbrace};
                        default: bytes = {bytes, ChRbrace};
                    endcase
                end
            endcase
        end
        if ($urandom_range(0, 7) == 0) bytes = {bytes, ChBackslash};
        for (k = 0; k < bytes.size(); k++) begin
            pending_rows = {pending_rows, itm(bytes[k], k == bytes.size() - 1)};
        end
    endtask

    always @(posedge aclk) begin
        if (ready_run == 0) begin
            if (m_ready) begin
                m_ready <= 1'b0;
                ready_run <= $urandom_range(1, 6);
            end else begin
                m_ready <= 1'b1;
                ready_run <= ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                         : $urandom_range(1, 10);
            end
        end else begin
            ready_run <= ready_run - 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected result: char_out %0h char_valid %0b end_of_text %0b",
                       m_char_out, m_char_valid, m_end_of_text);
                failures++;
            end else begin
                want = expected_chars.pop_front();
                if (m_char_out !== want.char_out) begin
                    $error("char_out: expected %0h, actual %0h", want.char_out, m_char_out);
                    failures++;
                end
                if (m_char_valid !== want.char_valid) begin
                    $error("char_valid: expected %0b, actual %0b", want.char_valid,
                           m_char_valid);
                    failures++;
                end
                if (m_end_of_text !== want.end_of_text) begin
                    $error("end_of_text: expected %0b, actual %0b", want.end_of_text,
                           m_end_of_text);
                    failures++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IdleLimit) begin
            $display("cad_text_code_filter_test failed");
            $finish;
        end
    end

    initial begin
        int phase;
        int k;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row(chk("A", 1'b1, 1, rs("A", 1'b1, 1'b1), '0));
        add_row(chk(ChBackslash, 1'b1, 1, rs(ChBackslash, 1'b1, 1'b1), '0));
        add_row(chk(ChLbrace, 1'b1, 1, rs(8'h00, 1'b0, 1'b1), '0));
        add_row(itm(8'h00, 1'b0));
        add_row(itm(ChBackslash, 1'b0));
        add_row(chk(ChLowerP, 1'b0, 1, rs(ChNewline, 1'b1, 1'b0), '0));
        add_row(itm(ChBackslash, 1'b0));
        add_row(itm(ChRbrace, 1'b0));
        add_row(itm(ChBackslash, 1'b0));
        add_row(itm("H", 1'b0));
        add_row(itm("1", 1'b0));
        add_row(itm(ChBackslash, 1'b0));
        add_row(itm("L", 1'b0));
        add_row(itm(ChSemicolon, 1'b0));
        add_row(itm(ChPercent, 1'b0));
        add_row(itm(ChPercent, 1'b0));
        add_row(chk("D", 1'b0, 2, rs(SymDegree0, 1'b1, 1'b0),
                    rs(SymDegree1, 1'b1, 1'b0)));
        add_row(itm(ChPercent, 1'b0));
        add_row(itm(ChPercent, 1'b0));
        add_row(itm("z", 1'b0));
        add_row(chk(8'hFF, 1'b1, 1, rs(8'hFF, 1'b1, 1'b1), '0));
        add_row(cfg(1'b0));
        add_row(itm(ChBackslash, 1'b0));
        add_row(itm(ChPercent, 1'b0));
        add_row(cfg(1'b1));
        add_row(itm(ChPercent, 1'b0));
        add_row(chk(ChLowerC, 1'b1, 2, rs(SymDiameter0, 1'b1, 1'b0),
                    rs(SymDiameter1, 1'b1, 1'b1)));

        for (k = 0; k < directed_rows.size(); k++) begin
            if (directed_rows[k].is_cfg) write_mode(directed_rows[k].ch[0]);
            else send_row(directed_rows[k]);
        end

        // phase boundaries may fall mid-string
        for (phase = 0; phase < 8; phase++) begin
            write_mode(RandModes[phase]);
            repeat (25) begin
                if (pending_rows.size() == 0) queue_string();
                send_row(pending_rows.pop_front());
            end
        end
        while (pending_rows.size() != 0) send_row(pending_rows.pop_front());

        if (s_valid) s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        if (failures == 0) begin
            $display("cad_text_code_filter_test passed");
        end else begin
            $display("cad_text_code_filter_test failed");
        end
        $finish;
    end

endmodule

### sim.f
hdl/ctcf_pkg.sv
hdl/cad_text_code_filter.sv
test/cad_text_code_filter_test.sv
